>>> src/mwdphe_pkg.sv
// shared types, constants and register codes of the mwd pulse height extractor
package mwdphe_pkg;

  localparam int unsigned DEF_MAX_DIFF_WINDOW = 1024;
  localparam int unsigned DEF_MAX_AVG_WINDOW  = 512;
  localparam int unsigned DEF_ACC_WIDTH       = 48;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned DIV_DIVIDEND_W = 64;
  localparam int unsigned DIV_DIVISOR_W  = 40;
  localparam int unsigned DIV_STEPS      = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY_COEFF,
    CFG_DIFF_WINDOW,
    CFG_AVG_WINDOW,
    CFG_AVG_RECIP,
    CFG_BASELINE_MARGIN,
    CFG_GRAD_THRESHOLD,
    CFG_LEARN_LENGTH,
    CFG_HOLDOFF_LENGTH
  } cfg_idx_e;

  localparam logic [23:0]        RST_DECAY_COEFF     = 24'd16776309;
  localparam logic [10:0]        RST_DIFF_WINDOW     = 11'd1000;
  localparam logic [9:0]         RST_AVG_WINDOW      = 10'd500;
  localparam logic [23:0]        RST_AVG_RECIP       = 24'd33554;
  localparam logic [15:0]        RST_BASELINE_MARGIN = 16'd40;
  localparam logic signed [16:0] RST_GRAD_THRESHOLD  = -17'sd26;
  localparam logic [19:0]        RST_LEARN_LENGTH    = 20'd100000;
  localparam logic [19:0]        RST_HOLDOFF_LENGTH  = 20'd150000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_DIFF,
    S_MAG,
    S_PH,
    S_PL,
    S_LVL,
    S_PROC,
    S_DIVST,
    S_DIV,
    S_MEAN,
    S_PEAK,
    S_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic load_x;
    logic mul;
    logic acc_upd;
    logic diff_upd;
    logic lvl_early;
    logic lvl_mag;
    logic lvl_ph;
    logic lvl_pl;
    logic lvl_set;
    logic set_post;
    logic hold_dec;
    logic hold_ld_learn;
    logic hold_ld_post;
    logic take_base;
    logic div_start;
    logic mean_ld;
    logic min_upd;
    logic emit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic proc_en;
    logic pre_learn;
    logic i_lt_m;
    logic i_le_learn;
    logic hold_nz;
    logic in_post;
    logic steep_learn;
    logic steep_post;
    logic count_nz;
    logic div_done;
    logic lt_thr;
    logic deepen;
    logic min_nz;
    logic eq_thr;
    logic out_free;
  } sts_t;

endpackage

>>> src/mwd_pulse_height_extractor_unit.sv
// top level of the moving window deconvolution pulse height extractor
// Each request carries one signed adc sample and is taken only while the block is idle.
// A sample runs through fewer states when the level is still the raw difference than when
// it is the scaled moving average. Once learning is over, every sample that is not
// rejected as a steep drop recomputes the baseline mean with a 64-step serial divider.
// A pulse result waits in an output register while the next samples are taken; a new
// result waits in the pulse step until that register is free, and this adds the stall
// cycles to its sample. Configuration writes go straight into the registers and are not
// held back until the next sample.
module mwd_pulse_height_extractor_unit import mwdphe_pkg::*; #(
  parameter int unsigned MAX_DIFF_WINDOW = DEF_MAX_DIFF_WINDOW,
  parameter int unsigned MAX_AVG_WINDOW  = DEF_MAX_AVG_WINDOW,
  parameter int unsigned ACC_WIDTH       = DEF_ACC_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [15:0]    adc_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [23:0]    peak_energy_o,
  output logic [39:0]           peak_sample_index_o,
  output logic [15:0]           peak_number_o
);

  cmd_t cmd;
  sts_t sts;

  mwdphe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mwdphe_datapath #(
    .MAX_DIFF_WINDOW (MAX_DIFF_WINDOW),
    .MAX_AVG_WINDOW  (MAX_AVG_WINDOW),
    .ACC_WIDTH       (ACC_WIDTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .adc_sample_i        (adc_sample_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .peak_energy_o       (peak_energy_o),
    .peak_sample_index_o (peak_sample_index_o),
    .peak_number_o       (peak_number_o)
  );

endmodule

>>> src/mwdphe_div.sv
// serial restoring divider for the baseline mean, one quotient bit per cycle
module mwdphe_div import mwdphe_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DIV_DIVIDEND_W-1:0] dividend_i,
  input  logic [DIV_DIVISOR_W-1:0]  divisor_i,
  output logic                      done_o,
  output logic [DIV_DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DIV_STEPS);

  logic [DIV_DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIV_DIVISOR_W-1:0]  dvs_q;
  logic [DIV_DIVIDEND_W-1:0] quo_q, quo_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic [DIV_DIVISOR_W:0]    trial;
  logic                      ge;

  assign trial = {rem_q, quo_q[DIV_DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DIV_DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIV_DIVISOR_W-1:0];
      quo_d = {quo_q[DIV_DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = !busy_q;
  assign quotient_o = quo_q;

endmodule

>>> src/mwdphe_datapath.sv
// filter, baseline and pulse datapath with delay memories and configuration registers
module mwdphe_datapath import mwdphe_pkg::*; #(
  parameter int unsigned MAX_DIFF_WINDOW = DEF_MAX_DIFF_WINDOW,
  parameter int unsigned MAX_AVG_WINDOW  = DEF_MAX_AVG_WINDOW,
  parameter int unsigned ACC_WIDTH       = DEF_ACC_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic signed [15:0]    adc_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [23:0]    peak_energy_o,
  output logic [39:0]           peak_sample_index_o,
  output logic [15:0]           peak_number_o
);

  localparam int unsigned DAW = (MAX_DIFF_WINDOW > 1) ? $clog2(MAX_DIFF_WINDOW) : 1;
  localparam int unsigned AAW = (MAX_AVG_WINDOW > 1) ? $clog2(MAX_AVG_WINDOW) : 1;
  localparam int unsigned MW  = DAW + 1;
  localparam int unsigned LW  = AAW + 1;
  localparam int unsigned DFW = $clog2(MAX_DIFF_WINDOW + 1);
  localparam int unsigned AFW = $clog2(MAX_AVG_WINDOW + 1);
  localparam int unsigned AW  = ACC_WIDTH;

  // configuration registers
  logic [23:0]        decay_q, recip_q;
  logic [10:0]        diff_win_q;
  logic [9:0]         avg_win_q;
  logic [15:0]        margin_q;
  logic signed [16:0] grad_thr_q;
  logic [19:0]        learn_q, holdoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q    <= RST_DECAY_COEFF;
      diff_win_q <= RST_DIFF_WINDOW;
      avg_win_q  <= RST_AVG_WINDOW;
      recip_q    <= RST_AVG_RECIP;
      margin_q   <= RST_BASELINE_MARGIN;
      grad_thr_q <= RST_GRAD_THRESHOLD;
      learn_q    <= RST_LEARN_LENGTH;
      holdoff_q  <= RST_HOLDOFF_LENGTH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DECAY_COEFF:     decay_q    <= cfg_wdata_i;
        CFG_DIFF_WINDOW:     diff_win_q <= cfg_wdata_i[10:0];
        CFG_AVG_WINDOW:      avg_win_q  <= cfg_wdata_i[9:0];
        CFG_AVG_RECIP:       recip_q    <= cfg_wdata_i;
        CFG_BASELINE_MARGIN: margin_q   <= cfg_wdata_i[15:0];
        CFG_GRAD_THRESHOLD:  grad_thr_q <= $signed(cfg_wdata_i[16:0]);
        CFG_LEARN_LENGTH:    learn_q    <= cfg_wdata_i[19:0];
        CFG_HOLDOFF_LENGTH:  holdoff_q  <= cfg_wdata_i[19:0];
      endcase
    end
  end

  // clamped windows
  logic [31:0]   dw32, aw32;
  logic [MW-1:0] m_w;
  logic [LW-1:0] l_w;

  assign dw32 = 32'(diff_win_q);
  assign aw32 = 32'(avg_win_q);

  always_comb begin
    if (dw32 == 32'd0) begin
      m_w = MW'(1);
    end else if (dw32 > MAX_DIFF_WINDOW) begin
      m_w = MW'(MAX_DIFF_WINDOW);
    end else begin
      m_w = MW'(dw32);
    end
    if (aw32 == 32'd0) begin
      l_w = LW'(1);
    end else if (aw32 > MAX_AVG_WINDOW) begin
      l_w = LW'(MAX_AVG_WINDOW);
    end else begin
      l_w = LW'(aw32);
    end
  end

  // sample state
  logic signed [15:0] x_q, prev_sample_q;
  logic [AW-1:0]      acc_q, acc_d, avg_q, avg_d, d_q, d_d;
  logic [DAW-1:0]     dpos_q;
  logic [AAW-1:0]     apos_q;
  logic [DFW-1:0]     dfill_q;
  logic [AFW-1:0]     afill_q;
  logic [39:0]        t_q, i_w;
  logic               wrapped_q, in_post_q;
  logic signed [31:0] level_q, pending_q, prev_level_q;
  logic [20:0]        hold_q;
  logic [63:0]        bsum_q;
  logic [39:0]        bcount_q;
  logic signed [31:0] min_q, mean_q;
  logic [39:0]        min_idx_q;
  logic [15:0]        peak_cnt_q;

  // delay line read addresses
  logic [MW-1:0]  dpos_ext, drd_full;
  logic [LW-1:0]  apos_ext, ard_full;
  logic [DAW-1:0] drd;
  logic [AAW-1:0] ard;

  assign dpos_ext = MW'(dpos_q);
  assign apos_ext = LW'(apos_q);
  assign drd_full = (dpos_ext >= m_w) ? dpos_ext - m_w
                                      : dpos_ext + MW'(MAX_DIFF_WINDOW) - m_w;
  assign ard_full = (apos_ext >= l_w) ? apos_ext - l_w
                                      : apos_ext + LW'(MAX_AVG_WINDOW) - l_w;
  assign drd = drd_full[DAW-1:0];
  assign ard = ard_full[AAW-1:0];

  // delay memories, unwritten entries read as zero through the fill counts
  logic [AW-1:0] dmem [MAX_DIFF_WINDOW];
  logic [AW-1:0] amem [MAX_AVG_WINDOW];
  logic [AW-1:0] dmem_rd_q, amem_rd_q;
  logic          dvalid_q, avalid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      dmem_rd_q <= dmem[drd];
      amem_rd_q <= amem[ard];
      dvalid_q  <= DFW'(drd) < dfill_q;
      avalid_q  <= AFW'(ard) < afill_q;
    end
    if (cmd_i.acc_upd) begin
      dmem[dpos_q] <= acc_d;
    end
    if (cmd_i.diff_upd) begin
      amem[apos_q] <= d_d;
    end
  end

  // deconvolution
  logic signed [40:0] p_q, p_rnd;
  logic [AW-1:0]      r_aw, x_aw;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      x_q <= adc_sample_i;
    end
    if (cmd_i.mul) begin
      p_q <= $signed({1'b0, decay_q}) * prev_sample_q;
    end
  end

  assign p_rnd = p_q + 41'sd32768;
  assign r_aw  = AW'(p_rnd >>> 16);
  assign x_aw  = AW'(x_q);
  assign acc_d = acc_q + (x_aw << 8) - r_aw;

  assign d_d   = acc_q - (dvalid_q ? dmem_rd_q : '0);
  assign avg_d = avg_q + d_d - (avalid_q ? amem_rd_q : '0);

  // level scaling
  logic               mag_neg_q;
  logic [AW-1:0]      mag_q;
  logic [63:0]        mag64;
  logic [55:0]        ph_q, pl_q;
  logic [34:0]        q_w;
  logic signed [31:0] lvl_scaled, lvl_sat;
  logic signed [63:0] d64;

  assign mag64 = 64'(mag_q);
  assign d64   = 64'($signed(d_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_upd) begin
      d_q <= d_d;
    end
    if (cmd_i.lvl_mag) begin
      mag_neg_q <= avg_q[AW-1];
      mag_q     <= avg_q[AW-1] ? AW'(-avg_q) : avg_q;
    end
    if (cmd_i.lvl_ph) begin
      ph_q <= 56'(mag64[63:32]) * 56'(recip_q);
    end
    if (cmd_i.lvl_pl) begin
      pl_q <= 56'(mag64[31:0]) * 56'(recip_q);
    end
  end

  always_comb begin
    if (ph_q >= 56'(1 << 24)) begin
      q_w = 35'h2_0000_0000;
    end else begin
      q_w = (35'(ph_q[23:0]) << 8) + 35'((pl_q + 56'd8388608) >> 24);
    end
    if (mag_neg_q) begin
      lvl_scaled = (q_w > 35'h0_8000_0000) ? 32'sh8000_0000 : 32'(-q_w);
    end else begin
      lvl_scaled = (q_w > 35'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q_w);
    end
    if (d64 > 64'sh7FFF_FFFF) begin
      lvl_sat = 32'sh7FFF_FFFF;
    end else if (d64 < -64'sh8000_0000) begin
      lvl_sat = 32'sh8000_0000;
    end else begin
      lvl_sat = 32'(d64);
    end
  end

  // gradient and baseline decisions
  logic signed [33:0] grad, thr_l, thr_p, pend34, thr_m;
  logic signed [32:0] e33;
  logic signed [23:0] e_sat;
  logic               sum_neg;
  logic [63:0]        dividend;
  logic [63:0]        quo;
  logic               div_done;
  logic signed [31:0] mean_d;

  assign i_w    = t_q - 40'd1;
  assign grad   = 34'(level_q) - 34'(pending_q);
  assign thr_l  = 34'(grad_thr_q);
  assign thr_p  = thr_l <<< 2;
  assign pend34 = 34'(pending_q);
  assign thr_m  = 34'(mean_q) - $signed({10'd0, margin_q, 8'd0});
  assign e33    = 33'(min_q) - 33'(mean_q);

  always_comb begin
    if (e33 > 33'sd8388607) begin
      e_sat = 24'sh7F_FFFF;
    end else if (e33 < -33'sd8388608) begin
      e_sat = 24'sh80_0000;
    end else begin
      e_sat = 24'(e33);
    end
  end

  assign sum_neg  = bsum_q[63];
  assign dividend = sum_neg ? -bsum_q : bsum_q;

  mwdphe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (bcount_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    if (sum_neg) begin
      mean_d = (quo > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-quo);
    end else begin
      mean_d = (quo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_ld) begin
      mean_q <= mean_d;
    end
    if (cmd_i.lvl_early) begin
      level_q <= lvl_sat;
    end else if (cmd_i.lvl_set) begin
      level_q <= lvl_scaled;
    end
  end

  // control-visible state
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sample_q <= '0;
      acc_q         <= '0;
      avg_q         <= '0;
      dpos_q        <= '0;
      apos_q        <= '0;
      dfill_q       <= '0;
      afill_q       <= '0;
      t_q           <= '0;
      wrapped_q     <= 1'b0;
      in_post_q     <= 1'b0;
      pending_q     <= '0;
      prev_level_q  <= '0;
      hold_q        <= '0;
      bsum_q        <= '0;
      bcount_q      <= '0;
      min_q         <= '0;
      min_idx_q     <= '0;
      peak_cnt_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.acc_upd) begin
        acc_q <= acc_d;
      end
      if (cmd_i.diff_upd) begin
        avg_q <= avg_d;
      end
      if (cmd_i.set_post) begin
        in_post_q <= 1'b1;
      end
      if (cmd_i.hold_ld_post) begin
        hold_q <= 21'(holdoff_q);
      end else if (cmd_i.hold_ld_learn) begin
        hold_q <= (holdoff_q != 20'd0) ? 21'(holdoff_q - 20'd1) : '0;
      end else if (cmd_i.hold_dec) begin
        hold_q <= hold_q - 21'd1;
      end else if (cmd_i.set_post) begin
        hold_q <= '0;
      end
      if (cmd_i.take_base) begin
        bsum_q   <= bsum_q + 64'(pending_q);
        bcount_q <= bcount_q + 40'd1;
      end
      if (cmd_i.min_upd) begin
        min_q     <= pending_q;
        min_idx_q <= i_w;
      end
      if (cmd_i.emit) begin
        peak_cnt_q  <= peak_cnt_q + 16'd1;
        min_q       <= '0;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        prev_level_q  <= pending_q;
        pending_q     <= level_q;
        prev_sample_q <= x_q;
        t_q           <= t_q + 40'd1;
        if (t_q == '1) begin
          wrapped_q <= 1'b1;
        end
        dpos_q <= (dpos_q == DAW'(MAX_DIFF_WINDOW - 1)) ? '0 : dpos_q + DAW'(1);
        apos_q <= (apos_q == AAW'(MAX_AVG_WINDOW - 1)) ? '0 : apos_q + AAW'(1);
        if (dfill_q != DFW'(MAX_DIFF_WINDOW)) begin
          dfill_q <= dfill_q + DFW'(1);
        end
        if (afill_q != AFW'(MAX_AVG_WINDOW)) begin
          afill_q <= afill_q + AFW'(1);
        end
      end
    end
  end

  logic signed [23:0] energy_q;
  logic [39:0]        index_q;
  logic [15:0]        number_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      energy_q <= e_sat;
      index_q  <= min_idx_q;
      number_q <= peak_cnt_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign peak_energy_o       = energy_q;
  assign peak_sample_index_o = index_q;
  assign peak_number_o       = number_q;

  always_comb begin
    sts_o.early       = !wrapped_q && ((41'(t_q) + 41'd1) < 41'(l_w));
    sts_o.proc_en     = (t_q != '0) || wrapped_q;
    sts_o.pre_learn   = !in_post_q && !wrapped_q;
    sts_o.i_lt_m      = i_w < 40'(m_w);
    sts_o.i_le_learn  = i_w <= 40'(learn_q);
    sts_o.hold_nz     = hold_q != '0;
    sts_o.in_post     = in_post_q;
    sts_o.steep_learn = grad < thr_l;
    sts_o.steep_post  = grad < thr_p;
    sts_o.count_nz    = bcount_q != '0;
    sts_o.div_done    = div_done;
    sts_o.lt_thr      = pend34 < thr_m;
    sts_o.deepen      = (pending_q < prev_level_q) && (pending_q < min_q);
    sts_o.min_nz      = min_q != '0;
    sts_o.eq_thr      = pend34 == thr_m;
    sts_o.out_free    = out_free;
  end

endmodule

>>> src/mwdphe_ctrl.sv
// sequencer that steps one sample through filter, baseline and pulse finding
module mwdphe_ctrl import mwdphe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_x = 1'b1;
          state_d      = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_upd = 1'b1;
        state_d       = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.diff_upd = 1'b1;
        state_d        = S_MAG;
      end
      S_MAG: begin
        if (sts_i.early) begin
          cmd_o.lvl_early = 1'b1;
          state_d         = S_PROC;
        end else begin
          cmd_o.lvl_mag = 1'b1;
          state_d       = S_PH;
        end
      end
      S_PH: begin
        cmd_o.lvl_ph = 1'b1;
        state_d      = S_PL;
      end
      S_PL: begin
        cmd_o.lvl_pl = 1'b1;
        state_d      = S_LVL;
      end
      S_LVL: begin
        cmd_o.lvl_set = 1'b1;
        state_d       = S_PROC;
      end
      S_PROC: begin
        state_d = S_FIN;
        if (sts_i.proc_en) begin
          if (sts_i.pre_learn && sts_i.i_lt_m) begin
            state_d = S_FIN;
          end else if (sts_i.pre_learn && sts_i.i_le_learn) begin
            priority if (sts_i.hold_nz) begin
              cmd_o.hold_dec = 1'b1;
            end else if (sts_i.steep_learn) begin
              cmd_o.hold_ld_learn = 1'b1;
            end else begin
              cmd_o.take_base = 1'b1;
            end
          end else begin
            // entering the post-learning phase clears a running holdoff unless a steep drop reloads it
            cmd_o.set_post = !sts_i.in_post;
            priority if (sts_i.in_post && sts_i.hold_nz) begin
              cmd_o.hold_dec = 1'b1;
              state_d        = S_DIVST;
            end else if (sts_i.steep_post) begin
              cmd_o.hold_ld_post = 1'b1;
            end else begin
              cmd_o.take_base = 1'b1;
              state_d         = S_DIVST;
            end
          end
        end
      end
      S_DIVST: begin
        if (sts_i.count_nz) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd_o.mean_ld = 1'b1;
        state_d       = S_PEAK;
      end
      S_PEAK: begin
        if (sts_i.lt_thr) begin
          cmd_o.min_upd = sts_i.deepen;
          state_d       = S_FIN;
        end else if (!sts_i.min_nz || sts_i.eq_thr) begin
          state_d = S_FIN;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;

endmodule
